// File: hw/rtl/chd_pkg.sv
// shared types, constants and helpers for the chunked body decoder
`default_nettype none

package chd_pkg;

    localparam int SIZE_BITS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 32;
    localparam int COUNT_OUT_BITS = 32;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [7:0] ASCII_SEMI = 8'h3B;
    localparam logic [7:0] ASCII_CR   = 8'h0D;
    localparam logic [7:0] ASCII_LF   = 8'h0A;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0]                out_byte;
        t_kind                     kind;
        logic [COUNT_OUT_BITS-1:0] consumed_count;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result result;
    } t_push;

    // bit 4 set when the byte is a hex digit, low nibble is its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/chd_if.sv
// stream interfaces for raw body bytes and decoded results
`default_nettype none

interface chd_byte_if
    import chd_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface chd_result_if
    import chd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [7:0]                out_byte;
    logic [1:0]                kind;
    logic [COUNT_OUT_BITS-1:0] consumed_count;

    modport source (output valid, output out_byte, output kind, output consumed_count,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input consumed_count,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/chd_parser.sv
// front end: takes body bytes, tracks framing and pushes results to the queue
`default_nettype none

module chd_parser
    import chd_pkg::*;
#(
    parameter int SIZE_BITS  = SIZE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    chd_byte_if.sink   i_in,
    input  wire        i_space,
    output t_push      o_push
);

    typedef enum logic [2:0] {
        PH_SIZE,
        PH_EXT,
        PH_SIZE_LF,
        PH_DATA,
        PH_DATA_CR,
        PH_DATA_LF
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [SIZE_BITS-1:0]  r_chunk, n_chunk;
    logic                  r_seen, n_seen;
    logic [COUNT_BITS-1:0] r_total, n_total;

    logic                      w_accept;
    logic [7:0]                w_byte;
    logic [4:0]                w_hex;
    logic                      w_emit;
    logic                      w_finish;
    t_kind                     w_kind;
    logic [COUNT_BITS-1:0]     w_total_inc;
    logic [COUNT_OUT_BITS-1:0] w_count;

    assign i_in.ready  = i_space;
    assign w_accept    = i_in.valid && i_space;
    assign w_byte      = i_in.in_byte;
    assign w_hex       = hex_digit(w_byte);
    // count including the current byte, saturating
    assign w_total_inc = (&r_total) ? r_total : r_total + 1'b1;

    // reported count is clamped to the output width
    generate
        if (COUNT_BITS > COUNT_OUT_BITS) begin : g_clamp
            assign w_count = (|w_total_inc[COUNT_BITS-1:COUNT_OUT_BITS])
                           ? '1 : w_total_inc[COUNT_OUT_BITS-1:0];
        end else begin : g_extend
            assign w_count = COUNT_OUT_BITS'(w_total_inc);
        end
    endgenerate

    always_comb begin
        n_phase  = r_phase;
        n_chunk  = r_chunk;
        n_seen   = r_seen;
        n_total  = w_total_inc;
        w_emit   = 1'b0;
        w_finish = 1'b0;
        w_kind   = KIND_DATA;

        case (r_phase)
            PH_SIZE: begin
                if (w_hex[4]) begin
                    // another digit would push the size past its width
                    if (r_chunk[SIZE_BITS-1 -: 4] != 4'd0) begin
                        w_finish = 1'b1;
                        w_kind   = KIND_ERR;
                    end else begin
                        n_chunk = {r_chunk[SIZE_BITS-5:0], w_hex[3:0]};
                        n_seen  = 1'b1;
                    end
                end else if (!r_seen) begin
                    w_finish = 1'b1;
                    w_kind   = KIND_ERR;
                end else if (w_byte == ASCII_SEMI) begin
                    n_phase = PH_EXT;
                end else if (w_byte == ASCII_CR) begin
                    n_phase = PH_SIZE_LF;
                end else begin
                    w_finish = 1'b1;
                    w_kind   = KIND_ERR;
                end
            end
            PH_EXT: begin
                if (w_byte == ASCII_CR) begin
                    n_phase = PH_SIZE_LF;
                end
            end
            PH_SIZE_LF: begin
                if (w_byte != ASCII_LF) begin
                    w_finish = 1'b1;
                    w_kind   = KIND_ERR;
                end else if (r_chunk == '0) begin
                    w_finish = 1'b1;
                    w_kind   = KIND_END;
                end else begin
                    n_seen  = 1'b0;
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_chunk = r_chunk - 1'b1;
                w_emit  = 1'b1;
                if (r_chunk == SIZE_BITS'(1)) begin
                    n_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                if (w_byte != ASCII_CR) begin
                    w_finish = 1'b1;
                    w_kind   = KIND_ERR;
                end else begin
                    n_phase = PH_DATA_LF;
                end
            end
            PH_DATA_LF: begin
                if (w_byte != ASCII_LF) begin
                    w_finish = 1'b1;
                    w_kind   = KIND_ERR;
                end else begin
                    n_phase = PH_SIZE;
                    n_chunk = '0;
                    n_seen  = 1'b0;
                end
            end
            default: begin
                w_finish = 1'b1;
                w_kind   = KIND_ERR;
            end
        endcase

        o_push.valid                 = w_accept && (w_emit || w_finish);
        o_push.result.out_byte       = w_emit ? w_byte : 8'd0;
        o_push.result.kind           = w_kind;
        o_push.result.consumed_count = w_count;

        // end or error starts a fresh message
        if (w_finish) begin
            n_phase = PH_SIZE;
            n_chunk = '0;
            n_seen  = 1'b0;
            n_total = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIZE;
            r_chunk <= '0;
            r_seen  <= 1'b0;
            r_total <= '0;
        end else if (w_accept) begin
            r_phase <= n_phase;
            r_chunk <= n_chunk;
            r_seen  <= n_seen;
            r_total <= n_total;
        end
    end

    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_chunk != '0))
        else $error("data phase with no bytes left");

    a_data_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_phase == PH_DATA) |-> (o_push.valid && o_push.result.kind == KIND_DATA))
        else $error("payload byte not pushed");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.valid && o_push.result.kind != KIND_DATA)
        |=> (r_phase == PH_SIZE && r_total == '0 && !r_seen))
        else $error("message state not cleared after end or error");

endmodule

`default_nettype wire

// File: hw/rtl/chd_queue.sv
// back end: short result queue that drives the output stream
`default_nettype none

module chd_queue
    import chd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  t_push         i_push,
    output logic          o_space,
    chd_result_if.source  o_out
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    t_result               r_slots [DEPTH];
    logic [PTR_BITS-1:0]   r_wr, n_wr;
    logic [PTR_BITS-1:0]   r_rd, n_rd;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  w_pop;
    t_result               w_head;

    assign o_space = (r_count < CNT_BITS'(DEPTH));
    assign w_pop   = o_out.valid && o_out.ready;
    assign w_head  = r_slots[r_rd];

    assign o_out.valid          = (r_count != '0);
    assign o_out.out_byte       = w_head.out_byte;
    assign o_out.kind           = w_head.kind;
    assign o_out.consumed_count = w_head.consumed_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.valid) begin
            n_wr = (r_wr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push.valid && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slots[r_wr] <= i_push.result;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> o_space)
        else $error("push into a full queue");

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.valid && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule

`default_nettype wire

// File: hw/rtl/http_chunked_body_decoder.sv
// top level of the chunked transfer body decoder
`default_nettype none

// Decodes an HTTP chunked body arriving one byte per item on i_in and delivers
// one result item per payload byte, one at the end of each message (zero-size
// chunk) and one on any framing error; size lines, extensions and CR LF are
// consumed silently. One byte is taken every cycle while the result queue
// (QUEUE_DEPTH entries) has room; a result is queued as its byte is accepted and
// reaches o_out after the results ahead of it. Bytes are parsed combinationally,
// so throughput is one byte per clock, limited only by the output side draining
// the queue. After an end or error result the next byte starts a new message.

module http_chunked_body_decoder
    import chd_pkg::*;
#(
    parameter int SIZE_BITS  = SIZE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    chd_byte_if.sink      i_in,
    chd_result_if.source  o_out
);

    t_push w_push;
    logic  w_space;

    chd_parser #(
        .SIZE_BITS  (SIZE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_space (w_space),
        .o_push  (w_push)
    );

    chd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_space (w_space),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
